>>> rtl/scl_pkg.sv
package scl_pkg;

  localparam int CharW      = 8;
  localparam int MaskW      = 64;
  localparam int KindW      = 3;
  localparam int ClassW     = 4;
  localparam int MaxResults = 4;
  localparam int ResCntW    = $clog2(MaxResults + 1);
  localparam int ResIdxW    = $clog2(MaxResults);
  localparam int QueueDepth = 2;

  localparam logic [MaskW-1:0] SepMaskReset = 64'h0000_0001_0000_0600;

  localparam logic [CharW-1:0] CharAmp    = 8'h26;
  localparam logic [CharW-1:0] CharBar    = 8'h7c;
  localparam logic [CharW-1:0] CharGt     = 8'h3e;
  localparam logic [CharW-1:0] CharLt     = 8'h3c;
  localparam logic [CharW-1:0] CharSquote = 8'h27;
  localparam logic [CharW-1:0] CharDquote = 8'h22;

  typedef enum logic [3:0] {
    MODE_BETWEEN   = 4'd0,
    MODE_WORD_CMD  = 4'd1,
    MODE_WORD_ARG  = 4'd2,
    MODE_QUOTE_CMD = 4'd3,
    MODE_QUOTE_ARG = 4'd4,
    MODE_PEND_AMP  = 4'd5,
    MODE_PEND_BAR  = 4'd6,
    MODE_PEND_GT   = 4'd7,
    MODE_TGT_SKIP  = 4'd8,
    MODE_TGT       = 4'd9,
    MODE_DROP      = 4'd10
  } scl_mode_t;

  typedef enum logic [KindW-1:0] {
    KIND_CHAR = 3'd0,
    KIND_END  = 3'd1,
    KIND_OP   = 3'd2,
    KIND_ERR  = 3'd3,
    KIND_EOL  = 3'd4
  } scl_kind_t;

  typedef enum logic [ClassW-1:0] {
    CLASS_CMD    = 4'd0,
    CLASS_DQUOTE = 4'd1,
    CLASS_SQUOTE = 4'd2,
    CLASS_WORD   = 4'd3,
    CLASS_OUT    = 4'd4,
    CLASS_IN     = 4'd5,
    CLASS_APPEND = 4'd6,
    CLASS_PIPE   = 4'd7,
    CLASS_AND    = 4'd8,
    CLASS_OR     = 4'd9,
    CLASS_BG     = 4'd10
  } scl_class_t;

  typedef enum logic [1:0] {
    TGT_OUT    = 2'd0,
    TGT_IN     = 2'd1,
    TGT_APPEND = 2'd2
  } scl_tgt_t;

  typedef struct packed {
    scl_mode_t mode;
    logic      expect_command;
    logic      quote_is_single;
    scl_tgt_t  target_class;
  } scl_state_t;

  localparam scl_state_t StateReset = '{
    mode: MODE_BETWEEN, expect_command: 1'b1, quote_is_single: 1'b0, target_class: TGT_OUT
  };

  typedef struct packed {
    scl_kind_t        kind;
    scl_class_t       cls;
    logic [CharW-1:0] ch;
  } scl_result_t;

  typedef struct packed {
    logic [ResCntW-1:0]                 count;
    scl_result_t [MaxResults-1:0]       res;
  } scl_bundle_t;

  function automatic scl_class_t scl_mode_class(scl_mode_t mode, logic quote_is_single,
                                                scl_tgt_t target_class);
    scl_class_t cls;
    unique case (mode) inside
      MODE_WORD_ARG:           cls = CLASS_WORD;
      MODE_QUOTE_ARG:          cls = quote_is_single ? CLASS_SQUOTE : CLASS_DQUOTE;
      MODE_TGT_SKIP, MODE_TGT: begin
        unique case (target_class)
          TGT_IN:     cls = CLASS_IN;
          TGT_APPEND: cls = CLASS_APPEND;
          default:    cls = CLASS_OUT;
        endcase
      end
      default:                 cls = CLASS_CMD;
    endcase
    return cls;
  endfunction

  function automatic logic scl_is_op(logic [CharW-1:0] c);
    return (c == CharAmp) || (c == CharBar) || (c == CharGt) || (c == CharLt);
  endfunction

endpackage

>>> rtl/scl_char_if.sv
interface scl_char_if import scl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] line_char;
  logic             line_last;

  modport source(output valid, output line_char, output line_last, input ready);
  modport sink(input valid, input line_char, input line_last, output ready);
endinterface

>>> rtl/scl_event_if.sv
interface scl_event_if import scl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  event_kind;
  logic [ClassW-1:0] token_class;
  logic [CharW-1:0]  token_char;
  logic              run_end;

  modport source(output valid, output event_kind, output token_class, output token_char,
                 output run_end, input ready);
  modport sink(input valid, input event_kind, input token_class, input token_char,
               input run_end, output ready);
endinterface

>>> rtl/scl_cfg_if.sv
interface scl_cfg_if import scl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MaskW-1:0] separator_mask;

  modport source(output valid, output separator_mask, input ready);
  modport sink(input valid, input separator_mask, output ready);
endinterface

>>> rtl/scl_front.sv
module scl_front import scl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  scl_char_if.sink    chars,
  scl_cfg_if.sink     cfg,
  input  logic        full,
  output logic        push,
  output scl_bundle_t bundle
);

  scl_state_t       state;
  scl_state_t       state_next;
  scl_state_t       fed;
  logic [MaskW-1:0] sep_mask;
  logic             accept;
  logic             is_sep;
  logic [CharW-1:0] c;

  function automatic scl_bundle_t append(scl_bundle_t b, scl_kind_t kind, scl_class_t cls,
                                         logic [CharW-1:0] ch);
    scl_bundle_t r;
    r = b;
    r.res[b.count[ResIdxW-1:0]] = '{kind: kind, cls: cls, ch: ch};
    r.count = b.count + ResCntW'(1);
    return r;
  endfunction

  assign c           = chars.line_char;
  assign chars.ready = !full;
  assign cfg.ready   = 1'b1;
  assign accept      = chars.valid && chars.ready;
  assign is_sep      = (c[CharW-1:6] == '0) && sep_mask[c[5:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_mask <= SepMaskReset;
      state    <= StateReset;
    end else begin
      if (cfg.valid) begin
        sep_mask <= cfg.separator_mask;
      end
      state <= state_next;
    end
  end

  // Next state: the character is fed first, then the end of line resets everything.
  always_comb begin
    logic again;
    fed   = state;
    again = 1'b1;
    unique case (state.mode) inside
      MODE_PEND_AMP, MODE_PEND_BAR: begin
        fed.expect_command = 1'b1;
        fed.mode           = MODE_BETWEEN;
        again              = (c != ((state.mode == MODE_PEND_AMP) ? CharAmp : CharBar));
      end
      MODE_PEND_GT: begin
        fed.mode = MODE_TGT_SKIP;
        if (c == CharGt) begin
          fed.target_class = TGT_APPEND;
          again            = 1'b0;
        end else begin
          fed.target_class = TGT_OUT;
        end
      end
      default: again = 1'b1;
    endcase
    if (again) begin
      unique case (fed.mode) inside
        MODE_WORD_CMD, MODE_WORD_ARG, MODE_TGT: begin
          if (is_sep) begin
            fed.mode = MODE_BETWEEN;
          end
        end
        MODE_QUOTE_CMD, MODE_QUOTE_ARG: begin
          if (c == (fed.quote_is_single ? CharSquote : CharDquote)) begin
            fed.mode = MODE_BETWEEN;
          end
        end
        MODE_TGT_SKIP: begin
          if (!is_sep) begin
            fed.mode = MODE_TGT;
          end
        end
        MODE_DROP: fed.mode = MODE_DROP;
        default: begin
          fed.mode = MODE_BETWEEN;
          if (!is_sep) begin
            if (scl_is_op(c)) begin
              if (fed.expect_command) begin
                fed.mode = MODE_DROP;
              end else if (c == CharAmp) begin
                fed.mode = MODE_PEND_AMP;
              end else if (c == CharBar) begin
                fed.mode = MODE_PEND_BAR;
              end else if (c == CharGt) begin
                fed.mode = MODE_PEND_GT;
              end else begin
                fed.target_class = TGT_IN;
                fed.mode         = MODE_TGT_SKIP;
              end
            end else if (c == CharSquote || c == CharDquote) begin
              fed.quote_is_single = (c == CharSquote);
              fed.mode            = fed.expect_command ? MODE_QUOTE_CMD : MODE_QUOTE_ARG;
              fed.expect_command  = 1'b0;
            end else begin
              fed.mode           = fed.expect_command ? MODE_WORD_CMD : MODE_WORD_ARG;
              fed.expect_command = 1'b0;
            end
          end
        end
      endcase
    end
    if (!accept) begin
      state_next = state;
    end else if (chars.line_last) begin
      state_next = StateReset;
    end else begin
      state_next = fed;
    end
  end

  // Outputs: the events caused by the character, then those of the end of line.
  always_comb begin
    logic       again;
    logic       dbl;
    scl_mode_t  mode2;
    logic       expc2;
    scl_tgt_t   tgt2;
    scl_class_t cls2;
    bundle = '0;
    again  = 1'b1;
    dbl    = 1'b0;
    mode2  = state.mode;
    expc2  = state.expect_command;
    tgt2   = state.target_class;
    unique case (state.mode) inside
      MODE_PEND_AMP: begin
        dbl    = (c == CharAmp);
        bundle = append(bundle, KIND_OP, dbl ? CLASS_AND : CLASS_BG, '0);
        again  = !dbl;
        mode2  = MODE_BETWEEN;
        expc2  = 1'b1;
      end
      MODE_PEND_BAR: begin
        dbl    = (c == CharBar);
        bundle = append(bundle, KIND_OP, dbl ? CLASS_OR : CLASS_PIPE, '0);
        again  = !dbl;
        mode2  = MODE_BETWEEN;
        expc2  = 1'b1;
      end
      MODE_PEND_GT: begin
        again = (c != CharGt);
        mode2 = MODE_TGT_SKIP;
        tgt2  = TGT_OUT;
      end
      default: again = 1'b1;
    endcase
    cls2 = scl_mode_class(mode2, state.quote_is_single, tgt2);
    if (again) begin
      unique case (mode2) inside
        MODE_WORD_CMD, MODE_WORD_ARG, MODE_TGT: begin
          bundle = is_sep ? append(bundle, KIND_END, cls2, '0)
                          : append(bundle, KIND_CHAR, cls2, c);
        end
        MODE_QUOTE_CMD, MODE_QUOTE_ARG: begin
          if (c == (state.quote_is_single ? CharSquote : CharDquote)) begin
            bundle = append(bundle, KIND_END, cls2, '0);
          end else begin
            bundle = append(bundle, KIND_CHAR, cls2, c);
          end
        end
        MODE_TGT_SKIP: begin
          if (!is_sep) begin
            bundle = append(bundle, KIND_CHAR, cls2, c);
          end
        end
        MODE_DROP: bundle = bundle;
        default: begin
          if (!is_sep) begin
            if (scl_is_op(c)) begin
              if (expc2) begin
                bundle = append(bundle, KIND_ERR, CLASS_CMD, c);
              end
            end else if (c != CharSquote && c != CharDquote) begin
              bundle = append(bundle, KIND_CHAR, expc2 ? CLASS_CMD : CLASS_WORD, c);
            end
          end
        end
      endcase
    end
    if (chars.line_last) begin
      unique case (fed.mode) inside
        MODE_WORD_CMD, MODE_WORD_ARG, MODE_QUOTE_CMD, MODE_QUOTE_ARG,
        MODE_TGT_SKIP, MODE_TGT: begin
          bundle = append(bundle, KIND_END,
                          scl_mode_class(fed.mode, fed.quote_is_single, fed.target_class), '0);
        end
        MODE_PEND_AMP: bundle = append(bundle, KIND_OP, CLASS_BG, '0);
        MODE_PEND_BAR: bundle = append(bundle, KIND_OP, CLASS_PIPE, '0);
        MODE_PEND_GT:  bundle = append(bundle, KIND_END, CLASS_OUT, '0);
        default:       bundle = bundle;
      endcase
      bundle = append(bundle, KIND_EOL, CLASS_CMD, '0);
    end
  end

  assign push = accept && (bundle.count != '0);

endmodule

>>> rtl/scl_queue.sv
module scl_queue import scl_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  scl_bundle_t push_data,
  input  logic        pop,
  output scl_bundle_t head,
  output logic        empty,
  output logic        full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  scl_bundle_t         entries [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     fill;

  assign empty = (fill == '0);
  assign full  = (fill == CntW'(Depth));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/scl_back.sv
module scl_back import scl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  scl_bundle_t head,
  input  logic        empty,
  output logic        pop,
  scl_event_if.source events
);

  logic [ResIdxW-1:0] idx;
  logic               load;
  logic               is_last;
  scl_result_t        cur;

  assign load    = !empty && (!events.valid || events.ready);
  assign cur     = head.res[idx];
  assign is_last = ((ResCntW'(idx) + ResCntW'(1)) == head.count);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      events.valid <= 1'b0;
      idx          <= '0;
    end else begin
      if (load) begin
        events.valid <= 1'b1;
        idx          <= is_last ? '0 : idx + ResIdxW'(1);
      end else if (events.ready) begin
        events.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      events.event_kind  <= cur.kind;
      events.token_class <= cur.cls;
      events.token_char  <= cur.ch;
      events.run_end     <= is_last;
    end
  end

endmodule

>>> rtl/shell_command_line_lexer.sv
// Command-line lexer: one character in per transfer on chars, token events out on events.
// A chars transfer carries line_char and line_last; line_last marks the final character of
// a line, after which the open token is closed and an end-of-line event follows.
// Each character causes zero to four events; run_end marks the last event of a character.
// The cfg channel writes the separator mask and is always ready; write it only while idle.
// The front end classifies a character in the cycle of its transfer and queues its events
// as one group; the back end sends them from an output register, one per cycle while
// events.ready is high. The input accepts a new character whenever the queue is not full,
// also while earlier events are still waiting in the queue or the output register.
// Characters that cause no event never occupy the queue.
// When events.ready is low, the output register holds its event, the queue fills, and
// chars.ready drops once the queue is full.
// Reset clears the lexer state to "between tokens, command expected", empties the queue
// and the output register, and restores the separator mask to space, tab and newline.
module shell_command_line_lexer import scl_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input logic         clk,
  input logic         rst,
  scl_char_if.sink    chars,
  scl_cfg_if.sink     cfg,
  scl_event_if.source events
);

  logic        push;
  logic        pop;
  logic        empty;
  logic        full;
  scl_bundle_t push_data;
  scl_bundle_t head;

  scl_front u_front (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .cfg    (cfg),
    .full   (full),
    .push   (push),
    .bundle (push_data)
  );

  scl_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  scl_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .events (events)
  );

endmodule

>>> verif/lexer_checker.sv
module lexer_checker import scl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  scl_char_if   chars,
  scl_cfg_if    cfg,
  scl_event_if  events,
  output int    fail_count,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    scl_kind_t        kind;
    scl_class_t       cls;
    logic [CharW-1:0] ch;
    logic             run_end;
  } lex_event_t;

  logic [MaskW-1:0] sep_mask;
  scl_mode_t        mode;
  logic             expect_cmd;
  logic             quote_single;
  scl_tgt_t         tgt;

  lex_event_t token_events[$];
  lex_event_t expected_events[$];

  function automatic bit is_separator(logic [CharW-1:0] c);
    return (c < 64) && sep_mask[c[5:0]];
  endfunction

  function automatic scl_class_t open_class();
    case (mode)
      MODE_WORD_ARG: return CLASS_WORD;
      MODE_QUOTE_ARG: return quote_single ? CLASS_SQUOTE : CLASS_DQUOTE;
      MODE_TGT_SKIP, MODE_TGT: begin
        if (tgt == TGT_IN) return CLASS_IN;
        if (tgt == TGT_APPEND) return CLASS_APPEND;
        return CLASS_OUT;
      end
      default: return CLASS_CMD;
    endcase
  endfunction

  function automatic void emit(scl_kind_t k, scl_class_t cl, logic [CharW-1:0] ch);
    token_events.push_back('{kind: k, cls: cl, ch: ch, run_end: 1'b0});
  endfunction

  task automatic lex_char(input logic [CharW-1:0] c, input logic last);
    bit again;
    bit dbl;
    token_events.delete();
    do begin
      again = 1'b0;
      case (mode)
        MODE_WORD_CMD, MODE_WORD_ARG, MODE_TGT: begin
          if (is_separator(c)) begin
            emit(KIND_END, open_class(), '0);
            mode = MODE_BETWEEN;
          end else begin
            emit(KIND_CHAR, open_class(), c);
          end
        end
        MODE_QUOTE_CMD, MODE_QUOTE_ARG: begin
          if (c == (quote_single ? CharSquote : CharDquote)) begin
            emit(KIND_END, open_class(), '0);
            mode = MODE_BETWEEN;
          end else begin
            emit(KIND_CHAR, open_class(), c);
          end
        end
        MODE_PEND_AMP: begin
          dbl = (c == CharAmp);
          emit(KIND_OP, dbl ? CLASS_AND : CLASS_BG, '0);
          expect_cmd = 1'b1;
          mode = MODE_BETWEEN;
          again = !dbl;
        end
        MODE_PEND_BAR: begin
          dbl = (c == CharBar);
          emit(KIND_OP, dbl ? CLASS_OR : CLASS_PIPE, '0);
          expect_cmd = 1'b1;
          mode = MODE_BETWEEN;
          again = !dbl;
        end
        MODE_PEND_GT: begin
          mode = MODE_TGT_SKIP;
          if (c == CharGt) begin
            tgt = TGT_APPEND;
          end else begin
            tgt = TGT_OUT;
            again = 1'b1;
          end
        end
        MODE_TGT_SKIP: begin
          if (!is_separator(c)) begin
            mode = MODE_TGT;
            emit(KIND_CHAR, open_class(), c);
          end
        end
        MODE_DROP: begin
        end
        default: begin
          mode = MODE_BETWEEN;
          if (!is_separator(c)) begin
            if (c == CharAmp || c == CharBar || c == CharLt || c == CharGt) begin
              if (expect_cmd) begin
                emit(KIND_ERR, CLASS_CMD, c);
                mode = MODE_DROP;
              end else if (c == CharAmp) begin
                mode = MODE_PEND_AMP;
              end else if (c == CharBar) begin
                mode = MODE_PEND_BAR;
              end else if (c == CharGt) begin
                mode = MODE_PEND_GT;
              end else begin
                tgt = TGT_IN;
                mode = MODE_TGT_SKIP;
              end
            end else if (c == CharSquote || c == CharDquote) begin
              quote_single = (c == CharSquote);
              mode = expect_cmd ? MODE_QUOTE_CMD : MODE_QUOTE_ARG;
              expect_cmd = 1'b0;
            end else begin
              mode = expect_cmd ? MODE_WORD_CMD : MODE_WORD_ARG;
              expect_cmd = 1'b0;
              emit(KIND_CHAR, open_class(), c);
            end
          end
        end
      endcase
    end while (again);

    if (last) begin
      case (mode)
        MODE_WORD_CMD, MODE_WORD_ARG, MODE_QUOTE_CMD, MODE_QUOTE_ARG, MODE_TGT_SKIP,
        MODE_TGT: emit(KIND_END, open_class(), '0);
        MODE_PEND_AMP: emit(KIND_OP, CLASS_BG, '0);
        MODE_PEND_BAR: emit(KIND_OP, CLASS_PIPE, '0);
        MODE_PEND_GT: emit(KIND_END, CLASS_OUT, '0);
        default: begin
        end
      endcase
      emit(KIND_EOL, CLASS_CMD, '0);
      mode = MODE_BETWEEN;
      expect_cmd = 1'b1;
      quote_single = 1'b0;
      tgt = TGT_OUT;
    end

    if (token_events.size() > 0) token_events[token_events.size() - 1].run_end = 1'b1;
    foreach (token_events[i]) expected_events.push_back(token_events[i]);
  endtask

  always @(posedge clk) begin
    lex_event_t want;
    if (rst) begin
      sep_mask = SepMaskReset;
      mode = MODE_BETWEEN;
      expect_cmd = 1'b1;
      quote_single = 1'b0;
      tgt = TGT_OUT;
      expected_events.delete();
      fail_count = 0;
    end else begin
      if (events.valid && events.ready) begin
        if (expected_events.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected event, expected none,", $time,
                   " actual kind %0d class %0d char 0x%02h run_end %0b",
                   events.event_kind, events.token_class, events.token_char,
                   events.run_end);
        end else begin
          want = expected_events.pop_front();
          if (events.event_kind !== want.kind || events.token_class !== want.cls ||
              events.token_char !== want.ch || events.run_end !== want.run_end) begin
            fail_count++;
            $display("%0t: event mismatch,", $time,
                     " expected kind %0d class %0d char 0x%02h run_end %0b,",
                     want.kind, want.cls, want.ch, want.run_end,
                     " actual kind %0d class %0d char 0x%02h run_end %0b",
                     events.event_kind, events.token_class, events.token_char,
                     events.run_end);
          end
        end
      end
      if (cfg.valid && cfg.ready) sep_mask = cfg.separator_mask;
      if (chars.valid && chars.ready) lex_char(chars.line_char, chars.line_last);
    end
    pending = expected_events.size();
  end

endmodule

>>> verif/testbench.sv
module testbench import scl_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseCount = 6;
  localparam int CharsPerPhase = 70;
  localparam int StuckLimit = 1000;

  logic clk = 1'b0;
  logic rst;
  bit   allow_idle;
  int   chars_sent;
  int   fail_count;
  int   pending;
  int   stall_left;
  int   stuck_cycles;

  scl_char_if  chars_if();
  scl_cfg_if   cfg_if();
  scl_event_if events_if();

  shell_command_line_lexer uut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .cfg    (cfg_if),
    .events (events_if)
  );

  lexer_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars_if),
    .cfg        (cfg_if),
    .events     (events_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (allow_idle && stall_left == 0 && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6);
    end
    events_if.ready <= (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (events_if.valid && events_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [CharW-1:0] c, input logic last);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      chars_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.line_char <= c;
    chars_if.line_last <= last;
    do @(posedge clk); while (!chars_if.ready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [CharW-1:0] word_char();
    if ($urandom_range(0, 5) == 0) return CharW'($urandom_range(1, 255));
    return CharW'($urandom_range(8'h61, 8'h7a));
  endfunction

  function automatic logic [CharW-1:0] sep_char();
    case ($urandom_range(0, 3))
      0: return 8'h09;
      1: return 8'h0a;
      2: return CharW'($urandom_range(1, 63));
      default: return 8'h20;
    endcase
  endfunction

  task automatic send_random_line();
    logic [CharW-1:0] line[$];
    logic [CharW-1:0] q;
    int parts;
    parts = $urandom_range(1, 5);
    for (int p = 0; p < parts; p++) begin
      if (p > 0 && $urandom_range(0, 9) < 7) line.push_back(sep_char());
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 4)) line.push_back(word_char());
        4, 5: begin
          q = $urandom_range(0, 1) ? CharSquote : CharDquote;
          line.push_back(q);
          repeat ($urandom_range(0, 3)) begin
            line.push_back($urandom_range(0, 3) == 0 ? sep_char() : word_char());
          end
          if ($urandom_range(0, 4) != 0) line.push_back(q);
        end
        6: begin
          q = $urandom_range(0, 1) ? CharAmp : CharBar;
          line.push_back(q);
          if ($urandom_range(0, 1)) line.push_back(q);
          if ($urandom_range(0, 1)) line.push_back(sep_char());
          repeat ($urandom_range(1, 3)) line.push_back(word_char());
        end
        7: begin
          case ($urandom_range(0, 2))
            0: line.push_back(CharLt);
            1: line.push_back(CharGt);
            default: begin
              line.push_back(CharGt);
              line.push_back(CharGt);
            end
          endcase
          if ($urandom_range(0, 1)) line.push_back(sep_char());
          repeat ($urandom_range(0, 3)) line.push_back(word_char());
        end
        default: line.push_back(CharW'($urandom_range(1, 255)));
      endcase
    end
    foreach (line[i]) send_char(line[i], i == line.size() - 1);
  endtask

  task automatic wait_drained();
    chars_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mask(input logic [MaskW-1:0] m);
    cfg_if.valid <= 1'b1;
    cfg_if.separator_mask <= m;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [MaskW-1:0] m;
    rst = 1'b1;
    allow_idle = 1'b1;
    chars_sent = 0;
    chars_if.valid = 1'b0;
    chars_if.line_char = '0;
    chars_if.line_last = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.separator_mask = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_line("\"x y\"z");
    send_line("a||''&");
    send_line("b>>f <g");
    send_line("c|d&&e>");
    send_line("&x");
    send_char(8'hff, 1'b1);
    send_char(8'h01, 1'b1);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1: m = '0;
          2: m = '1;
          3: m = {$urandom, $urandom};
          4: m = ({$urandom, $urandom} & {$urandom, $urandom}) | SepMaskReset;
          default: m = SepMaskReset;
        endcase
        write_mask(m);
      end
      allow_idle = (ph < PhaseCount - 1);
      while (chars_sent < (ph + 1) * CharsPerPhase) send_random_line();
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/scl_pkg.sv
rtl/scl_char_if.sv
rtl/scl_event_if.sv
rtl/scl_cfg_if.sv
rtl/scl_front.sv
rtl/scl_queue.sv
rtl/scl_back.sv
rtl/shell_command_line_lexer.sv
verif/lexer_checker.sv
verif/testbench.sv
